FILE: rtl/core/quicksort_batch_sorter_unit_defines.svh
// assertion helpers shared by the sorter rtl
`ifndef QUICKSORT_BATCH_SORTER_UNIT_DEFINES_SVH
`define QUICKSORT_BATCH_SORTER_UNIT_DEFINES_SVH

// same-cycle implication, held off while in reset
`define QBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed");

// next-cycle implication, held off while in reset
`define QBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed");

`endif

FILE: rtl/core/qbs_pkg.sv
`default_nettype none

package qbs_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // what one cell holds and hands to its neighbors
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } cell_data_t;

    // chain-wide control, one action per cycle
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/qbs_cell.sv
`default_nettype none

module qbs_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire qbs_pkg::cell_ctrl_t            ctrl,
    input  wire logic [qbs_pkg::VALUE_W-1:0]    new_value,
    input  wire qbs_pkg::cell_data_t            prev_data,
    input  wire logic                           prev_gt,
    input  wire qbs_pkg::cell_data_t            next_data,
    output qbs_pkg::cell_data_t                 data,
    output logic                                gt
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [qbs_pkg::VALUE_W-1:0]    value_reg;
    logic [qbs_pkg::VALUE_W-1:0]    value_next;

    // an empty cell counts as +infinity, so the insert point is monotone along the row
    assign gt = !valid_reg || ($signed(new_value) < $signed(value_reg));

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert && gt)
        begin
            if (prev_gt)
            begin
                valid_next = prev_data.valid;
                value_next = prev_data.value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = new_value;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = next_data.valid;
            value_next = next_data.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign data.valid = valid_reg;
    assign data.value = value_reg;

endmodule

`default_nettype wire

FILE: rtl/core/qbs_chain.sv
`default_nettype none

module qbs_chain (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire qbs_pkg::cell_ctrl_t            ctrl,
    input  wire logic [qbs_pkg::VALUE_W-1:0]    new_value,
    output qbs_pkg::cell_data_t                 head,
    output logic                                second_valid
);

    qbs_pkg::cell_data_t    cell_data [qbs_pkg::CAPACITY];
    logic                   cell_gt   [qbs_pkg::CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < qbs_pkg::CAPACITY; gi++)
        begin : g_cell
            qbs_pkg::cell_data_t    prev_d;
            logic                   prev_g;
            qbs_pkg::cell_data_t    next_d;

            if (gi == 0)
            begin : g_first
                assign prev_d = '0;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_d = cell_data[gi-1];
                assign prev_g = cell_gt[gi-1];
            end

            if (gi == qbs_pkg::CAPACITY - 1)
            begin : g_tail
                assign next_d = '0;
            end
            else
            begin : g_body
                assign next_d = cell_data[gi+1];
            end

            qbs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_value (new_value),
                .prev_data (prev_d),
                .prev_gt   (prev_g),
                .next_data (next_d),
                .data      (cell_data[gi]),
                .gt        (cell_gt[gi])
            );
        end
    endgenerate

    assign head         = cell_data[0];
    assign second_valid = cell_data[1].valid;

endmodule

`default_nettype wire

FILE: rtl/core/quicksort_batch_sorter_unit.sv
`default_nettype none

// batch sorter: signed 32-bit values stream in one item per cycle, the item with
// tlast closes the batch, and the batch then streams out in ascending order with
// tlast on the final value. sorting happens while loading: a row of CAPACITY
// compare-and-insert cells keeps the held values in order, each new item is
// compared against every cell at once and the larger values move one cell along,
// so loading sustains one item per cycle with no sort phase afterward. once the
// batch is closed the row shifts toward the head one place per accepted output
// item, so with a sink that never stalls the values leave one per cycle. input is not
// accepted while a batch is being emitted, so a new batch cannot start loading
// until the previous one has left. values past CAPACITY in one batch are dropped,
// and a closing item whose value is dropped still ends the batch.

`include "quicksort_batch_sorter_unit_defines.svh"

module quicksort_batch_sorter_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [31:0]    s_tdata,     // [31:0] value
    input  wire logic           s_tlast,     // last
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,     // [31:0] sorted_value
    output logic                m_tlast      // end_of_run
);

    // control state
    logic [qbs_pkg::COUNT_W-1:0]    count_reg;
    logic [qbs_pkg::COUNT_W-1:0]    count_next;
    logic                           emit_reg;
    logic                           emit_next;

    logic                           in_accept;
    logic                           out_accept;
    logic                           room;
    qbs_pkg::cell_ctrl_t            ctrl;
    qbs_pkg::cell_data_t            head;
    logic                           second_valid;

    // handshakes: load side is open only between batches
    assign s_tready   = !emit_reg;
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;
    assign room       = (count_reg < qbs_pkg::COUNT_W'(qbs_pkg::CAPACITY));

    // insert only while the row has a free cell, shift the row on each output item
    assign ctrl.insert = in_accept && room;
    assign ctrl.shift  = out_accept;

    always_comb
    begin
        count_next = count_reg;
        emit_next  = emit_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + qbs_pkg::COUNT_W'(1);
        end
        if (in_accept && s_tlast)
        begin
            emit_next = 1'b1;
        end
        // final item taken: batch done, ready for the next one
        if (out_accept && m_tlast)
        begin
            emit_next  = 1'b0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            emit_reg  <= emit_next;
        end
    end

    qbs_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .new_value    (s_tdata),
        .head         (head),
        .second_valid (second_valid)
    );

    // head cell is registered, so it serves directly as the output stage
    assign m_tvalid = emit_reg;
    assign m_tdata  = head.value;
    assign m_tlast  = head.valid && !second_valid;

    // checks on the sequencing
    `QBS_ASSERT_NOW(a_emit_has_data, clk, rst_n, m_tvalid, head.valid)
    `QBS_ASSERT_NEXT(a_close_starts_emit, clk, rst_n, in_accept && s_tlast, m_tvalid)
    `QBS_ASSERT_NEXT(a_tail_ends_emit, clk, rst_n, out_accept && m_tlast, !m_tvalid && !head.valid)
    `QBS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= qbs_pkg::COUNT_W'(qbs_pkg::CAPACITY))

endmodule

`default_nettype wire
